@@ rtl/aisnf_pkg.sv @@
`default_nettype none
package aisnf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned POS_W       = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAGMENT_TOTAL   = 3'd0,
    CFG_FRAG_INDEX       = 3'd1,
    CFG_SEQUENCE_DIGIT   = 3'd2,
    CFG_SEQUENCE_PRESENT = 3'd3,
    CFG_CHANNEL_B        = 3'd4
  } cfg_index_t;

  // character positions within a sentence
  localparam logic [POS_W-1:0] POS_BANG     = 5'd0;
  localparam logic [POS_W-1:0] POS_TAG_A    = 5'd1;
  localparam logic [POS_W-1:0] POS_TAG_I    = 5'd2;
  localparam logic [POS_W-1:0] POS_TAG_V    = 5'd3;
  localparam logic [POS_W-1:0] POS_TAG_D    = 5'd4;
  localparam logic [POS_W-1:0] POS_TAG_M    = 5'd5;
  localparam logic [POS_W-1:0] POS_COMMA0   = 5'd6;
  localparam logic [POS_W-1:0] POS_TOTAL    = 5'd7;
  localparam logic [POS_W-1:0] POS_COMMA1   = 5'd8;
  localparam logic [POS_W-1:0] POS_NUMBER   = 5'd9;
  localparam logic [POS_W-1:0] POS_COMMA2   = 5'd10;
  localparam logic [POS_W-1:0] POS_SEQ      = 5'd11;
  localparam logic [POS_W-1:0] POS_COMMA3   = 5'd12;
  localparam logic [POS_W-1:0] POS_CHANNEL  = 5'd13;
  localparam logic [POS_W-1:0] POS_COMMA4   = 5'd14;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 5'd15;
  localparam logic [POS_W-1:0] POS_COMMA5   = 5'd16;
  localparam logic [POS_W-1:0] POS_FILL     = 5'd17;
  localparam logic [POS_W-1:0] POS_STAR     = 5'd18;
  localparam logic [POS_W-1:0] POS_HEX_HI   = 5'd19;
  localparam logic [POS_W-1:0] POS_HEX_LO   = 5'd20;
  localparam logic [POS_W-1:0] POS_CR       = 5'd21;
  localparam logic [POS_W-1:0] POS_LAST     = 5'd22;

  typedef struct packed {
    logic [5:0] symbol;
    logic       final_symbol;
    logic [2:0] pad_bits;
    logic       first;
  } item_t;

  typedef struct packed {
    logic [3:0] fragment_total;
    logic [3:0] frag_index;
    logic [3:0] sequence_digit;
    logic       sequence_present;
    logic       channel_b;
  } cfg_t;

  function automatic logic [7:0] digit_char(input logic [3:0] v);
    digit_char = (v > 4'd9) ? 8'h39 : (8'h30 + {4'h0, v});
  endfunction

  function automatic logic [7:0] armor_char(input logic [5:0] s);
    armor_char = (s < 6'd40) ? ({2'b00, s} + 8'd48) : ({2'b00, s} + 8'd56);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

endpackage
`default_nettype wire

@@ rtl/aisnf_queue.sv @@
`default_nettype none
module aisnf_queue
  import aisnf_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   wr,
  input  item_t wr_item,
  output logic  q_full,
  input  wire   rd,
  output item_t rd_item,
  output logic  q_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = (count == FULL_COUNT);
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT) else $error("queue count over depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on write");
`endif

endmodule
`default_nettype wire

@@ rtl/aisnf_front.sv @@
`default_nettype none
module aisnf_front
  import aisnf_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire  [5:0] symbol,
  input  wire        final_symbol,
  input  wire  [2:0] pad_bits,
  input  wire        q_full,
  output logic       q_wr,
  output item_t      q_item
);

  logic inside_sentence;
  logic accept;

  assign accept = push && !q_full;
  assign q_wr   = accept;

  always_comb begin
    q_item.symbol       = symbol;
    q_item.final_symbol = final_symbol;
    q_item.pad_bits     = pad_bits;
    q_item.first        = !inside_sentence;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_sentence <= 1'b0;
    end else if (accept) begin
      inside_sentence <= !final_symbol;
    end
  end

endmodule
`default_nettype wire

@@ rtl/aisnf_back.sv @@
`default_nettype none
module aisnf_back
  import aisnf_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  cfg_t       cfg,
  input  item_t      q_item,
  input  wire        q_empty,
  output logic       q_rd,
  output logic       empty,
  input  wire        pop,
  output logic [7:0] character,
  output logic       sentence_end
);

  logic             busy;
  logic [POS_W-1:0] pos;
  item_t            held;
  logic [7:0]       running_xor;
  logic             out_valid;

  item_t            cur;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] pos_next;
  logic             have_item;
  logic             out_ready;
  logic             emit;
  logic             last;
  logic [7:0]       ch;

  assign cur       = busy ? held : q_item;
  assign pos_cur   = busy ? pos : (q_item.first ? POS_BANG : POS_PAYLOAD);
  assign have_item = busy || !q_empty;
  assign out_ready = !out_valid || pop;
  assign emit      = have_item && out_ready;
  assign q_rd      = !busy && !q_empty && out_ready;
  assign last      = (pos_cur == POS_LAST) ||
                     ((pos_cur == POS_PAYLOAD) && !cur.final_symbol);
  assign pos_next  = ((pos_cur == POS_COMMA2) && !cfg.sequence_present) ?
                     POS_COMMA3 : pos_cur + 1'b1;
  assign empty     = !out_valid;

  always_comb begin
    case (pos_cur)
      POS_BANG:    ch = 8'h21;
      POS_TAG_A:   ch = 8'h41;
      POS_TAG_I:   ch = 8'h49;
      POS_TAG_V:   ch = 8'h56;
      POS_TAG_D:   ch = 8'h44;
      POS_TAG_M:   ch = 8'h4D;
      POS_TOTAL:   ch = digit_char(cfg.fragment_total);
      POS_NUMBER:  ch = digit_char(cfg.frag_index);
      POS_SEQ:     ch = digit_char(cfg.sequence_digit);
      POS_CHANNEL: ch = cfg.channel_b ? 8'h42 : 8'h41;
      POS_PAYLOAD: ch = armor_char(cur.symbol);
      POS_FILL:    ch = 8'h30 + {5'b0, cur.pad_bits};
      POS_STAR:    ch = 8'h2A;
      POS_HEX_HI:  ch = hex_char(running_xor[7:4]);
      POS_HEX_LO:  ch = hex_char(running_xor[3:0]);
      POS_CR:      ch = 8'h0D;
      POS_LAST:    ch = 8'h0A;
      default:     ch = 8'h2C;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character    <= ch;
      sentence_end <= (pos_cur == POS_LAST);
      held         <= cur;
      pos          <= pos_next;
      if (pos_cur == POS_BANG) begin
        running_xor <= 8'h00;
      end else if (pos_cur <= POS_FILL) begin
        running_xor <= running_xor ^ ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        busy <= !last;
      end
      if (out_ready) begin
        out_valid <= have_item;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> !busy) else $error("sequencer busy after last character");
  a_held_pos: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos != POS_BANG)) else $error("held position at sentence start");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_rd) else $error("queue read while a transaction is in flight");
  a_end_is_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sentence_end) |-> (character == 8'h0A))
    else $error("sentence end not on line feed");
`endif

endmodule
`default_nettype wire

@@ rtl/ais_nmea_sentence_framer_top.sv @@
// Channel   Handshake                 Payload
// config    cfg_write                 cfg_index[2:0], cfg_data[3:0]
// input     push / full               symbol[5:0], final_symbol, pad_bits[2:0]
// output    empty / pop               character[7:0], sentence_end
//
// One character per cycle leaves the output sequencer unless pop is held off; a middle
// symbol gives one character, the first of a sentence adds the header before it and the
// final one adds fill, checksum and CR LF. The input queue (QUEUE_DEPTH entries) keeps
// taking symbols while the sequencer works. rst is synchronous; it clears the queue,
// sentence tracking and the output stage, and loads the register defaults.
`default_nettype none
module ais_nmea_sentence_framer_top
  import aisnf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_write,
  input  wire [CFG_INDEX_W-1:0] cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  input  wire                   push,
  output logic                  full,
  input  wire  [5:0]            symbol,
  input  wire                   final_symbol,
  input  wire  [2:0]            pad_bits,
  output logic                  empty,
  input  wire                   pop,
  output logic [7:0]            character,
  output logic                  sentence_end
);

  cfg_t  cfg;
  item_t wr_item;
  item_t rd_item;
  logic  q_wr;
  logic  q_rd;
  logic  q_full;
  logic  q_empty;

  assign full = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fragment_total   <= 4'd1;
      cfg.frag_index       <= 4'd1;
      cfg.sequence_digit   <= 4'd0;
      cfg.sequence_present <= 1'b0;
      cfg.channel_b        <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAGMENT_TOTAL:   cfg.fragment_total   <= cfg_data;
        CFG_FRAG_INDEX:       cfg.frag_index       <= cfg_data;
        CFG_SEQUENCE_DIGIT:   cfg.sequence_digit   <= cfg_data;
        CFG_SEQUENCE_PRESENT: cfg.sequence_present <= cfg_data[0];
        CFG_CHANNEL_B:        cfg.channel_b        <= cfg_data[0];
        default:              ;
      endcase
    end
  end

  aisnf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .symbol       (symbol),
    .final_symbol (final_symbol),
    .pad_bits     (pad_bits),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_item       (wr_item)
  );

  aisnf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (wr_item),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_item (rd_item),
    .q_empty (q_empty)
  );

  aisnf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_item       (rd_item),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .character    (character),
    .sentence_end (sentence_end)
  );

endmodule
`default_nettype wire

@@ verif/ais_nmea_sentence_framer_top_test.sv @@
`timescale 1ns / 1ps
module ais_nmea_sentence_framer_top_test;
  import aisnf_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 50;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } nmea_char_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [5:0]             symbol = '0;
  logic                   final_symbol = 1'b0;
  logic [2:0]             pad_bits = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [7:0]             character;
  logic                   sentence_end;

  cfg_t       shadow_cfg;
  logic [7:0] sum_acc;
  logic       in_sentence;
  nmea_char_t expected_chars[$];

  int errors = 0;
  int cycles = 0;
  int hold_requests = 0;
  int hold_served = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  ais_nmea_sentence_framer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .symbol       (symbol),
    .final_symbol (final_symbol),
    .pad_bits     (pad_bits),
    .empty        (empty),
    .pop          (pop),
    .character    (character),
    .sentence_end (sentence_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] ascii_digit(input logic [3:0] v);
    return (v > 4'd9) ? "9" : (8'h30 + {4'h0, v});
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h41 + {4'h0, n} - 8'd10);
  endfunction

  function automatic void queue_char(input logic [7:0] ch, input bit summed, input bit last);
    nmea_char_t c;
    c.ch = ch;
    c.last = last;
    expected_chars.insert(expected_chars.size(), c);
    if (summed) sum_acc = sum_acc ^ ch;
  endfunction

  // characters produced by one accepted symbol
  function automatic void predict_sentence_chars(input logic [5:0] s, input logic f,
                                                 input logic [2:0] p);
    logic [47:0] tag;
    logic [7:0]  sum;
    int          i;
    tag = "AIVDM,";
    if (!in_sentence) begin
      sum_acc = '0;
      queue_char("!", 1'b0, 1'b0);
      for (i = 0; i < 6; i++) queue_char(tag[47-8*i -: 8], 1'b1, 1'b0);
      queue_char(ascii_digit(shadow_cfg.fragment_total), 1'b1, 1'b0);
      queue_char(",", 1'b1, 1'b0);
      queue_char(ascii_digit(shadow_cfg.frag_index), 1'b1, 1'b0);
      queue_char(",", 1'b1, 1'b0);
      if (shadow_cfg.sequence_present)
        queue_char(ascii_digit(shadow_cfg.sequence_digit), 1'b1, 1'b0);
      queue_char(",", 1'b1, 1'b0);
      queue_char(shadow_cfg.channel_b ? "B" : "A", 1'b1, 1'b0);
      queue_char(",", 1'b1, 1'b0);
      in_sentence = 1'b1;
    end
    queue_char((s < 6'd40) ? ({2'b00, s} + 8'd48) : ({2'b00, s} + 8'd56), 1'b1, 1'b0);
    if (f) begin
      queue_char(",", 1'b1, 1'b0);
      queue_char(8'h30 + {5'h0, p}, 1'b1, 1'b0);
      sum = sum_acc;
      queue_char("*", 1'b0, 1'b0);
      queue_char(hex_digit(sum[7:4]), 1'b0, 1'b0);
      queue_char(hex_digit(sum[3:0]), 1'b0, 1'b0);
      queue_char(8'h0D, 1'b0, 1'b0);
      queue_char(8'h0A, 1'b0, 1'b1);
      sum_acc = '0;
      in_sentence = 1'b0;
    end
  endfunction

  task automatic send_symbol(input logic [5:0] s, input logic f, input logic [2:0] p);
    int gap;
    push <= 1'b1;
    symbol <= s;
    final_symbol <= f;
    pad_bits <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_sentence_chars(s, f, p);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [3:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_FRAGMENT_TOTAL:   shadow_cfg.fragment_total = value;
      CFG_FRAG_INDEX:       shadow_cfg.frag_index = value;
      CFG_SEQUENCE_DIGIT:   shadow_cfg.sequence_digit = value;
      CFG_SEQUENCE_PRESENT: shadow_cfg.sequence_present = value[0];
      CFG_CHANNEL_B:        shadow_cfg.channel_b = value[0];
      default: ;
    endcase
  endtask

  // single-bit registers get random upper data bits, which must be ignored
  task automatic set_config(input logic [3:0] total, input logic [3:0] number,
                            input logic [3:0] seq_digit, input logic seq_on,
                            input logic chan_b);
    logic [2:0] junk_a;
    logic [2:0] junk_b;
    junk_a = 3'($urandom_range(0, 7));
    junk_b = 3'($urandom_range(0, 7));
    write_reg(CFG_FRAGMENT_TOTAL, total);
    write_reg(CFG_FRAG_INDEX, number);
    write_reg(CFG_SEQUENCE_DIGIT, seq_digit);
    write_reg(CFG_SEQUENCE_PRESENT, {junk_a, seq_on});
    write_reg(CFG_CHANNEL_B, {junk_b, chan_b});
    cfg_write <= 1'b0;
  endtask

  initial begin : result_sink
    int         stall;
    int         hold_left;
    nmea_char_t want;
    stall = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report($sformatf("unexpected transaction: character 0x%02h end %0b",
                           character, sentence_end));
        end else begin
          want = expected_chars.pop_front();
          if (character !== want.ch)
            report($sformatf("character 0x%02h, want 0x%02h", character, want.ch));
          if (sentence_end !== want.last)
            report($sformatf("sentence_end %0b, want %0b (char 0x%02h)",
                             sentence_end, want.last, want.ch));
        end
        if (!rx_steady) stall = pick_gap();
      end
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic test_reset_defaults();
    send_symbol(6'd0, 1'b1, 3'd0);
    send_symbol(6'd63, 1'b1, 3'd5);
  endtask

  task automatic test_symbol_extremes();
    send_symbol(6'd0, 1'b0, 3'd0);
    send_symbol(6'd39, 1'b0, 3'd0);
    send_symbol(6'd40, 1'b0, 3'd0);
    send_symbol(6'd63, 1'b1, 3'd5);
    send_symbol(6'd21, 1'b1, 3'd6);
    send_symbol(6'd42, 1'b1, 3'd7);
  endtask

  task automatic test_pad_on_middle_symbol();
    send_symbol(6'd12, 1'b0, 3'd7);
    send_symbol(6'd50, 1'b0, 3'd5);
    send_symbol(6'd33, 1'b0, 3'd2);
    send_symbol(6'd1, 1'b1, 3'd4);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    set_config(4'd9, 4'd9, 4'd9, 1'b1, 1'b1);
    send_symbol(6'd7, 1'b0, 3'd0);
    send_symbol(6'd44, 1'b1, 3'd2);
    wait_drained();
    set_config(4'd15, 4'd10, 4'd12, 1'b1, 1'b0);
    send_symbol(6'd31, 1'b1, 3'd1);
    wait_drained();
    set_config(4'd0, 4'd0, 4'd15, 1'b0, 1'b1);
    send_symbol(6'd59, 1'b1, 3'd3);
    wait_drained();
    set_config(4'd1, 4'd1, 4'd0, 1'b1, 1'b0);
    send_symbol(6'd8, 1'b1, 3'd0);
    wait_drained();
  endtask

  task automatic test_write_mid_sentence();
    send_symbol(6'd25, 1'b0, 3'd0);
    wait_drained();
    set_config(4'd3, 4'd2, 4'd7, 1'b1, 1'b1);
    send_symbol(6'd48, 1'b1, 3'd4);
    send_symbol(6'd2, 1'b1, 3'd0);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    int k;
    int r;
    hold_requests++;
    tx_steady = 1'b1;
    for (k = 0; k < 30; k++) begin
      r = $urandom_range(0, 511);
      send_symbol(r[5:0], k == 29, r[8:6]);
    end
    tx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_sentences();
    int sent;
    int len;
    int k;
    int r;
    bit closed;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
      closed = ($urandom_range(0, 7) != 0);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 511);
        send_symbol(r[5:0], closed && (k == len - 1), r[8:6]);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        r = $urandom;
        set_config(r[3:0], r[7:4], r[11:8], r[12], r[13]);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    shadow_cfg.fragment_total = 4'd1;
    shadow_cfg.frag_index = 4'd1;
    shadow_cfg.sequence_digit = 4'd0;
    shadow_cfg.sequence_present = 1'b0;
    shadow_cfg.channel_b = 1'b0;
    sum_acc = '0;
    in_sentence = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_symbol_extremes();
    test_pad_on_middle_symbol();
    test_register_extremes();
    test_write_mid_sentence();
    test_output_backpressure();
    test_random_sentences();
    wait_drained();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
